[hw/rtl/tolp_pkg.sv]
// Package for the third-order lowpass IIR unit: widths, register indexes,
// controller states and the multiply-accumulate sequence table.
// No dependencies.
package tolp_pkg;

  localparam int SampleWidth = 16;
  localparam int HistFrac    = 16;
  localparam int AccWidth    = 96;
  localparam int DenWidth    = 50;
  localparam int CoefWidth   = 52;
  localparam int XsWidth     = 19;
  localparam int NumOps      = 13;
  localparam int DivSteps    = 16;

  localparam logic [7:0] CFG_GAIN   = 8'd0;
  localparam logic [7:0] CFG_DAMP   = 8'd1;
  localparam logic [7:0] CFG_FREQ   = 8'd2;
  localparam logic [7:0] CFG_PERIOD = 8'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_PREP, S_CHECK, S_DIV, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    A_NF, A_WT, A_DAMP, A_WT2_LO, A_WT2_HI, A_KWT2_LO, A_KWT2_HI, A_C_LO, A_C_HI
  } asel_e;

  typedef enum logic [2:0] {
    B_TS, B_WT, B_GAIN, B_XS, B_Y
  } bsel_e;

  typedef enum logic [1:0] {
    SG_POS, SG_X, SG_C
  } sgn_e;

  typedef enum logic [2:0] {
    L_NONE, L_WT, L_WT2, L_DWT, L_KWT2
  } latch_e;

  typedef struct packed {
    asel_e      a_sel;
    bsel_e      b_sel;
    logic [1:0] idx;
    logic [1:0] shift;  // product is shifted left by 16 times this
    sgn_e       sgn;
    logic       load;   // replace the accumulator instead of adding
    latch_e     latch;
  } op_t;

  typedef struct packed {
    logic start;
    logic mul;
    logic acc;
    logic prep;
    logic check;
    logic div;
    logic finish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } stat_t;

  function automatic op_t tolp_op(input logic [3:0] step);
    op_t o;
    o = '{a_sel: A_NF, b_sel: B_TS, idx: 2'd0, shift: 2'd0, sgn: SG_POS,
          load: 1'b1, latch: L_NONE};
    case (step)
      4'd0: o.latch = L_WT;
      4'd1: begin o.a_sel = A_WT; o.b_sel = B_WT; o.latch = L_WT2; end
      4'd2: begin o.a_sel = A_DAMP; o.b_sel = B_WT; o.latch = L_DWT; end
      4'd3: begin o.a_sel = A_WT2_LO; o.b_sel = B_GAIN; end
      4'd4: begin
        o.a_sel = A_WT2_HI; o.b_sel = B_GAIN; o.shift = 2'd2; o.load = 1'b0;
        o.latch = L_KWT2;
      end
      4'd5: begin o.a_sel = A_KWT2_LO; o.b_sel = B_XS; o.shift = 2'd1; o.sgn = SG_X; end
      4'd6: begin
        o.a_sel = A_KWT2_HI; o.b_sel = B_XS; o.shift = 2'd3; o.sgn = SG_X; o.load = 1'b0;
      end
      4'd7, 4'd9, 4'd11: begin
        o.a_sel = A_C_LO; o.b_sel = B_Y; o.sgn = SG_C; o.load = 1'b0;
        o.idx = 2'((step - 4'd7) >> 1);
      end
      4'd8, 4'd10, 4'd12: begin
        o.a_sel = A_C_HI; o.b_sel = B_Y; o.sgn = SG_C; o.load = 1'b0; o.shift = 2'd2;
        o.idx = 2'((step - 4'd8) >> 1);
      end
      default: o.load = 1'b1;
    endcase
    return o;
  endfunction

endpackage

[hw/rtl/tolp_if.sv]
// Channel interfaces of the lowpass IIR unit: sample input, filtered output
// and configuration write. Depends on nothing.
interface tolp_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface tolp_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample_out;
  logic              saturated;
  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

interface tolp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/tolp_ctrl.sv]
// Controller of the lowpass IIR unit: steps the multiply-accumulate sequence,
// the rounding preparation and the divider. Depends on tolp_pkg.
module tolp_ctrl
  import tolp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic [3:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL;
          step_d  = '0;
        end
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        if (step_q == 4'(NumOps - 1)) begin
          state_d = S_PREP;
        end else begin
          state_d = S_MUL;
          step_d  = step_q + 4'd1;
        end
      end
      S_PREP: state_d = S_CHECK;
      S_CHECK: begin
        state_d = S_DIV;
        cnt_d   = '0;
      end
      S_DIV: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(DivSteps - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_full) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = tolp_op(step_q);
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_MUL:   cmd_o.mul = 1'b1;
      S_ACC:   cmd_o.acc = 1'b1;
      S_PREP:  cmd_o.prep = 1'b1;
      S_CHECK: cmd_o.check = 1'b1;
      S_DIV:   cmd_o.div = 1'b1;
      S_DONE:  cmd_o.finish = !stat_i.out_full;
      default: in_ready_o = 1'b0;
    endcase
  end

endmodule

[hw/rtl/tolp_dp.sv]
// Datapath of the lowpass IIR unit: configuration registers, histories, the
// shared 32x32 multiplier, the 96-bit accumulator, the divider and the output
// register. Depends on tolp_pkg.
module tolp_dp
  import tolp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  input  logic                    cfg_we_i,
  input  logic [7:0]              cfg_idx_i,
  input  logic [31:0]             cfg_data_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SampleWidth-1:0] sample_o,
  output logic                    sat_o
);

  // Configuration.
  logic [15:0] gain_q, damp_q;
  logic [23:0] nf_q;
  logic [31:0] ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd256;
      damp_q <= 16'd4096;
      nf_q   <= 24'd256;
      ts_q   <= 32'd42949673;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN:   gain_q <= cfg_data_i[15:0];
        CFG_DAMP:   damp_q <= cfg_data_i[15:0];
        CFG_FREQ:   nf_q   <= cfg_data_i[23:0];
        CFG_PERIOD: ts_q   <= cfg_data_i;
        default:    gain_q <= gain_q;
      endcase
    end
  end

  // Histories.
  logic signed [SampleWidth-1:0] xh_q [3];
  logic signed [31:0]            yh_q [3];
  logic signed [SampleWidth-1:0] x_q;

  // Coefficients and operands.
  logic [31:0]          wt_q;
  logic [47:0]          wt2_q;
  logic [35:0]          dwt_q;
  logic [55:0]          kwt2_q;
  logic [CoefWidth-1:0] cmag_q [3];
  logic                 cneg_q [3];
  logic [DenWidth-1:0]  den_q;
  logic [XsWidth-1:0]   xsmag_q;
  logic                 xsneg_q;
  logic [31:0]          ymag_q [3];
  logic                 yneg_q [3];

  // Feedback taps as negated denominator terms, refreshed every cycle.
  logic signed [52:0] t2, td, cn [3];
  localparam logic signed [52:0] Four = 53'sd262144;

  always_comb begin
    t2    = $signed({5'b0, wt2_q});
    td    = $signed({15'b0, dwt_q, 2'b0});
    cn[0] = Four - (t2 <<< 1) - t2 - td;
    cn[1] = Four - (t2 <<< 1) - t2 + td;
    cn[2] = td - t2 - Four;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      cneg_q[i] <= cn[i][52];
      cmag_q[i] <= cn[i][52] ? CoefWidth'(-cn[i]) : CoefWidth'(cn[i]);
    end
    den_q <= {2'b0, wt2_q} + {12'b0, dwt_q, 2'b0} + DenWidth'(262144);
  end

  // Input sum and history magnitudes at request start.
  logic signed [XsWidth-1:0] xs;
  always_comb begin
    xs = XsWidth'(sample_i) + XsWidth'(3) * XsWidth'(xh_q[0])
         + XsWidth'(3) * XsWidth'(xh_q[1]) + XsWidth'(xh_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q     <= sample_i;
      xsneg_q <= xs[XsWidth-1];
      xsmag_q <= xs[XsWidth-1] ? XsWidth'(-xs) : XsWidth'(xs);
      for (int i = 0; i < 3; i++) begin
        yneg_q[i] <= yh_q[i][31];
        ymag_q[i] <= yh_q[i][31] ? 32'(-yh_q[i]) : 32'(yh_q[i]);
      end
    end
  end

  // Shared multiplier.
  logic [31:0] a_op, b_op;
  logic [63:0] p_d, p_q;
  op_t         op;
  assign op = cmd_i.op;

  always_comb begin
    case (op.a_sel)
      A_NF:      a_op = {8'b0, nf_q};
      A_WT:      a_op = wt_q;
      A_DAMP:    a_op = {16'b0, damp_q};
      A_WT2_LO:  a_op = wt2_q[31:0];
      A_WT2_HI:  a_op = {16'b0, wt2_q[47:32]};
      A_KWT2_LO: a_op = kwt2_q[31:0];
      A_KWT2_HI: a_op = {8'b0, kwt2_q[55:32]};
      A_C_LO:    a_op = cmag_q[op.idx][31:0];
      A_C_HI:    a_op = {12'b0, cmag_q[op.idx][51:32]};
      default:   a_op = '0;
    endcase
    case (op.b_sel)
      B_TS:    b_op = ts_q;
      B_WT:    b_op = wt_q;
      B_GAIN:  b_op = {16'b0, gain_q};
      B_XS:    b_op = {13'b0, xsmag_q};
      B_Y:     b_op = ymag_q[op.idx];
      default: b_op = '0;
    endcase
  end

  assign p_d = a_op * b_op;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_q <= p_d;
    end
  end

  // Accumulator.
  logic [AccWidth-1:0] acc_q, acc_d, term, sterm;
  logic                tneg;

  always_comb begin
    case (op.sgn)
      SG_X:    tneg = xsneg_q;
      SG_C:    tneg = cneg_q[op.idx] ^ yneg_q[op.idx];
      default: tneg = 1'b0;
    endcase
    term  = {32'b0, p_q} << {op.shift, 4'b0};
    sterm = tneg ? (~term + AccWidth'(1)) : term;
    acc_d = op.load ? sterm : acc_q + sterm;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      acc_q <= acc_d;
      case (op.latch)
        L_WT:    wt_q   <= acc_d[55:24];
        L_WT2:   wt2_q  <= acc_d[63:16];
        L_DWT:   dwt_q  <= acc_d[47:12];
        L_KWT2:  kwt2_q <= acc_d[63:8];
        default: wt_q   <= wt_q;
      endcase
    end
  end

  // Rounding offset, overflow check and two-bit-per-cycle restoring divider.
  logic                neg_q, ovf_q;
  logic [AccWidth-1:0] n_q;
  logic [DenWidth-1:0] rem_q;
  logic [31:0]         lo_q, q_q;
  logic [DenWidth:0]   r1, r2;
  logic [DenWidth-1:0] r1s, r2s;
  logic                ge1, ge2;

  always_comb begin
    r1  = {rem_q, lo_q[31]};
    ge1 = r1 >= {1'b0, den_q};
    r1s = ge1 ? DenWidth'(r1 - {1'b0, den_q}) : DenWidth'(r1);
    r2  = {r1s, lo_q[30]};
    ge2 = r2 >= {1'b0, den_q};
    r2s = ge2 ? DenWidth'(r2 - {1'b0, den_q}) : DenWidth'(r2);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      neg_q <= acc_q[AccWidth-1];
      n_q   <= (acc_q[AccWidth-1] ? (~acc_q + AccWidth'(1)) : acc_q)
               + AccWidth'(den_q >> 1);
    end
    if (cmd_i.check) begin
      // A quotient of 2^32 or more saturates anyway; otherwise the upper
      // numerator bits are already below the divisor.
      ovf_q <= n_q >= {14'b0, den_q, 32'b0};
      rem_q <= (n_q >= {14'b0, den_q, 32'b0}) ? '0 : n_q[81:32];
      lo_q  <= n_q[31:0];
      q_q   <= '0;
    end
    if (cmd_i.div) begin
      rem_q <= r2s;
      lo_q  <= {lo_q[29:0], 2'b0};
      q_q   <= {q_q[29:0], ge1, ge2};
    end
  end

  // History clip, output rounding and saturation.
  logic [31:0]            ylim, ymag;
  logic                   ysat, osat;
  logic [16:0]            rr, olim, rc;
  logic signed [31:0]     y_new;
  logic [SampleWidth-1:0] out_d;

  always_comb begin
    ylim  = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
    ysat  = ovf_q || (q_q > ylim);
    ymag  = ysat ? ylim : q_q;
    y_new = neg_q ? $signed(-ymag) : $signed(ymag);
    rr    = 17'(({1'b0, ymag} + 33'(1 << (HistFrac - 1))) >> HistFrac);
    olim  = neg_q ? 17'd32768 : 17'd32767;
    osat  = rr > olim;
    rc    = osat ? olim : rr;
    out_d = neg_q ? SampleWidth'(-rc) : SampleWidth'(rc);
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
      xh_q[2] <= xh_q[1];
      xh_q[1] <= xh_q[0];
      xh_q[0] <= x_q;
      yh_q[2] <= yh_q[1];
      yh_q[1] <= yh_q[0];
      yh_q[0] <= y_new;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_o <= $signed(out_d);
      sat_o    <= ysat || osat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_full = out_valid_q && !out_ready_i;

  // The remainder must stay below the divisor for the quotient bits to hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.div |-> rem_q < den_q)
    else $error("divider remainder not below divisor");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.finish |=> out_valid_q)
    else $error("result not presented after finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while output stalled");

endmodule

[hw/rtl/third_order_lowpass_iir_unit.sv]
// Top level of the third-order lowpass IIR unit.
// Depends on tolp_pkg, tolp_if, tolp_ctrl and tolp_dp.

// A sample request runs from acceptance to a result in the output register
// as 13 passes through the shared 32x32 multiplier, each a multiply state
// and an accumulate state (coefficients, feed-forward and three feedback
// products), then rounding and overflow check, a divider that yields two
// quotient bits per cycle, and a final state that loads the output
// register. No new request is taken before then; the next is accepted in the
// cycle after the result is registered, while it still waits to be taken. A
// result is registered only once the previous one has been taken.
// Configuration writes are always accepted and must come while idle.
module third_order_lowpass_iir_unit
  import tolp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tolp_in_if.sink    in_i,
  tolp_out_if.source out_o,
  tolp_cfg_if.sink   cfg_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  tolp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tolp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .sample_i    (in_i.sample_in),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sample_o    (out_o.sample_out),
    .sat_o       (out_o.saturated)
  );

endmodule
